// ----- rtl/core/pism_pkg.sv -----
// pism_pkg: opcode and status codes plus field widths of the
// predicated integer stack machine; no dependencies
`timescale 1ns / 1ps

package pism_pkg;

  localparam int KIND_W   = 4;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 5;

  localparam logic [KIND_W-1:0] KIND_SEP  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ELSE = 4'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH = 4'd2;
  localparam logic [KIND_W-1:0] KIND_ADD  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_SUB  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_MUL  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_DIV  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_MOD  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_EQ   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_GT   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_LT   = 4'd10;
  localparam logic [KIND_W-1:0] KIND_AND  = 4'd11;
  localparam logic [KIND_W-1:0] KIND_OR   = 4'd12;
  localparam logic [KIND_W-1:0] KIND_NOT  = 4'd13;
  localparam logic [KIND_W-1:0] KIND_IF   = 4'd14;
  localparam logic [KIND_W-1:0] KIND_POP  = 4'd15;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd4;

  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

endpackage

// ----- rtl/core/predicated_integer_stack_machine_top.sv -----
// predicated_integer_stack_machine_top: stack machine with sequencer, stack
// memory, alu and restoring divider; depends on pism_pkg
`timescale 1ns / 1ps

// One opcode beat is taken at a time and yields exactly one result beat.
// Sep, else, push, not, skipped opcodes and opcodes that hit underflow or
// overflow go from decode to the result beat; if and pop also read the new
// top (not when the stack ends empty), the alu operators read an operand and
// write back, and div and mod read an operand; the divider then resolves one
// quotient bit per cycle, then a sign fixup and a write-back follow (a zero
// divisor ends after the operand read). The input is stalled from acceptance
// until the result beat is taken. The stack lives in a single memory with
// one write and one registered read port; the top entry is also kept in a
// register so most opcodes need no memory read.

module predicated_integer_stack_machine_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pism_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [pism_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pism_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_top_valid,
  output logic signed [pism_pkg::DATA_W-1:0]  out_top_value,
  output logic [pism_pkg::DEPTH_W-1:0]        out_depth,
  output logic                                out_store_valid,
  output logic signed [pism_pkg::DATA_W-1:0]  out_store_value
);
  import pism_pkg::*;

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_EXEC, S_DIV, S_SGN, S_WR, S_RDT, S_TOP, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [DATA_W-1:0]   value_r, value_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                run_r, run_nxt;
  logic [DATA_W-1:0]   top_r, top_nxt;
  logic [DATA_W-1:0]   res_r, res_nxt;
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   dvs_r, dvs_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                neg_q_r, neg_q_nxt;
  logic                neg_r_r, neg_r_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                sv_r, sv_nxt;
  logic [DATA_W-1:0]   sval_r, sval_nxt;

  logic [DATA_W-1:0]   mem [STACK_DEPTH];
  logic [DATA_W-1:0]   mem_rdata_r;
  logic                mem_we;
  logic [IW-1:0]       mem_widx;
  logic [DATA_W-1:0]   mem_wdata;
  logic [IW-1:0]       mem_ridx;

  logic [CW-1:0]       cnt_m1;
  logic [CW-1:0]       cnt_m2;
  logic [DATA_W-1:0]   opa;
  logic [DATA_W-1:0]   opb;
  logic [DATA_W-1:0]   alu_res;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W:0]     rem_diff;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);
  assign opa    = top_r;
  assign opb    = mem_rdata_r;
  assign rem_sh   = {rem_r, quo_r[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  always_comb begin
    case (kind_r)
      KIND_ADD: alu_res = opa + opb;
      KIND_SUB: alu_res = opa - opb;
      KIND_MUL: alu_res = opa * opb;
      KIND_EQ:  alu_res = DATA_W'(opa == opb);
      KIND_GT:  alu_res = DATA_W'($signed(opa) > $signed(opb));
      KIND_LT:  alu_res = DATA_W'($signed(opa) < $signed(opb));
      KIND_AND: alu_res = DATA_W'((opa != '0) && (opb != '0));
      default:  alu_res = DATA_W'((opa != '0) || (opb != '0));
    endcase
  end

  // stack memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_ridx];
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    value_nxt  = value_r;
    count_nxt  = count_r;
    run_nxt    = run_r;
    top_nxt    = top_r;
    res_nxt    = res_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    step_nxt   = step_r;
    neg_q_nxt  = neg_q_r;
    neg_r_nxt  = neg_r_r;
    status_nxt = status_r;
    sv_nxt     = sv_r;
    sval_nxt   = sval_r;
    mem_we     = 1'b0;
    mem_widx   = cnt_m1[IW-1:0];
    mem_wdata  = res_r;
    mem_ridx   = cnt_m1[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_kind;
          value_nxt  = in_value;
          status_nxt = ST_OK;
          sv_nxt     = 1'b0;
          sval_nxt   = '0;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_OUT;
        if (kind_r == KIND_SEP) begin
          run_nxt = 1'b1;
        end else if (kind_r == KIND_ELSE) begin
          run_nxt = ~run_r;
        end else if (!run_r) begin
          status_nxt = ST_SKIPPED;
        end else if (kind_r == KIND_PUSH) begin
          if (count_r == CW'(STACK_DEPTH)) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            mem_we    = 1'b1;
            mem_widx  = count_r[IW-1:0];
            mem_wdata = value_r;
            top_nxt   = value_r;
            count_nxt = count_r + CW'(1);
          end
        end else if (kind_r == KIND_NOT || kind_r == KIND_IF || kind_r == KIND_POP) begin
          if (count_r == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else if (kind_r == KIND_NOT) begin
            mem_we    = 1'b1;
            mem_wdata = DATA_W'(top_r == '0);
            top_nxt   = DATA_W'(top_r == '0);
          end else begin
            if (kind_r == KIND_IF) begin
              run_nxt = (top_r != '0);
            end else begin
              sv_nxt   = 1'b1;
              sval_nxt = top_r;
            end
            count_nxt = cnt_m1;
            state_nxt = S_RDT;
          end
        end else begin
          if (count_r < CW'(2)) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            mem_ridx  = cnt_m2[IW-1:0];
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (kind_r == KIND_DIV || kind_r == KIND_MOD) begin
          if (opb == '0) begin
            status_nxt = ST_DIV_ZERO;
            state_nxt  = S_OUT;
          end else begin
            quo_nxt   = opa[DATA_W-1] ? -opa : opa;
            dvs_nxt   = opb[DATA_W-1] ? -opb : opb;
            rem_nxt   = '0;
            step_nxt  = STEP_W'(DIV_STEPS - 1);
            neg_q_nxt = opa[DATA_W-1] ^ opb[DATA_W-1];
            neg_r_nxt = opa[DATA_W-1];
            state_nxt = S_DIV;
          end
        end else begin
          res_nxt   = alu_res;
          state_nxt = S_WR;
        end
      end
      S_DIV: begin
        if (!rem_diff[DATA_W]) begin
          rem_nxt = rem_diff[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DATA_W-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = S_SGN;
        end
      end
      S_SGN: begin
        if (kind_r == KIND_MOD) begin
          res_nxt = neg_r_r ? -rem_r : rem_r;
        end else begin
          res_nxt = neg_q_r ? -quo_r : quo_r;
        end
        state_nxt = S_WR;
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_widx  = cnt_m2[IW-1:0];
        mem_wdata = res_r;
        top_nxt   = res_r;
        count_nxt = cnt_m1;
        state_nxt = S_OUT;
      end
      S_RDT: begin
        state_nxt = (count_r == '0) ? S_OUT : S_TOP;
      end
      S_TOP: begin
        top_nxt   = mem_rdata_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      run_r    <= 1'b1;
      status_r <= ST_OK;
      sv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      run_r    <= run_nxt;
      status_r <= status_nxt;
      sv_r     <= sv_nxt;
    end
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    top_r   <= top_nxt;
    res_r   <= res_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    step_r  <= step_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    sval_r  <= sval_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_status      = status_r;
  assign out_top_valid   = (count_r != '0);
  assign out_top_value   = (count_r != '0) ? top_r : '0;
  assign out_depth       = DEPTH_W'(count_r);
  assign out_store_valid = sv_r;
  assign out_store_value = sval_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count above depth");

  a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_store_valid) |-> (out_status == ST_OK))
    else $error("pop beat with error status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("not busy after input beat");

  a_skip_holds_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK && !$past(out_valid)) |-> $stable(count_r))
    else $error("stack depth moved on error");
`endif

endmodule

// ----- tb/predicated_integer_stack_machine_top_tb.sv -----
// predicated_integer_stack_machine_top_tb: self-checking bench for the stack machine;
// a local predictor of stack, run flag and status is checked beat by beat against
// the result channel. depends on pism_pkg and predicated_integer_stack_machine_top
`timescale 1ns / 1ps

module predicated_integer_stack_machine_top_tb;
  import pism_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                top_valid;
    logic [DATA_W-1:0]   top_value;
    logic [DEPTH_W-1:0]  depth;
    logic                store_valid;
    logic [DATA_W-1:0]   store_value;
  } step_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind;
  logic [DATA_W-1:0]   in_value;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic                out_top_valid;
  logic [DATA_W-1:0]   out_top_value;
  logic [DEPTH_W-1:0]  out_depth;
  logic                out_store_valid;
  logic [DATA_W-1:0]   out_store_value;

  logic                rx_hold;
  int                  gap_pct;
  int                  stall_pct;
  int                  stall_left;
  int                  items_sent;
  int                  mismatch_count;
  int                  cycle_count;

  // predictor state
  logic [DATA_W-1:0]   stack_mirror [STACK_DEPTH];
  int                  stack_fill;
  logic                run_mirror;
  step_result_t        pending_results [$];

  predicated_integer_stack_machine_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_top_valid  (out_top_valid),
    .out_top_value  (out_top_value),
    .out_depth      (out_depth),
    .out_store_valid(out_store_valid),
    .out_store_value(out_store_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic step_result_t execute_opcode(input logic [KIND_W-1:0] kind,
                                                  input logic [DATA_W-1:0] imm);
    step_result_t r;
    logic [DATA_W-1:0] a, b, res;
    longint sa, sb;
    r = '0;
    res = '0;
    if (kind == KIND_SEP) begin
      run_mirror = 1'b1;
    end else if (kind == KIND_ELSE) begin
      run_mirror = ~run_mirror;
    end else if (!run_mirror) begin
      r.status = ST_SKIPPED;
    end else if (kind == KIND_PUSH) begin
      if (stack_fill >= STACK_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        stack_mirror[stack_fill] = imm;
        stack_fill++;
      end
    end else if (kind inside {KIND_NOT, KIND_IF, KIND_POP}) begin
      if (stack_fill < 1) begin
        r.status = ST_UNDERFLOW;
      end else begin
        a = stack_mirror[stack_fill - 1];
        if (kind == KIND_NOT) begin
          stack_mirror[stack_fill - 1] = (a == '0) ? 32'd1 : 32'd0;
        end else if (kind == KIND_IF) begin
          stack_fill--;
          run_mirror = (a != '0);
        end else begin
          stack_fill--;
          r.store_valid = 1'b1;
          r.store_value = a;
        end
      end
    end else if (stack_fill < 2) begin
      r.status = ST_UNDERFLOW;
    end else begin
      a = stack_mirror[stack_fill - 1];
      b = stack_mirror[stack_fill - 2];
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      case (kind)
        KIND_ADD: res = a + b;
        KIND_SUB: res = a - b;
        KIND_MUL: res = a * b;
        KIND_DIV: begin
          if (b == '0) r.status = ST_DIV_ZERO;
          else res = 32'(sa / sb);
        end
        KIND_MOD: begin
          if (b == '0) r.status = ST_DIV_ZERO;
          else res = 32'(sa % sb);
        end
        KIND_EQ:  res = (a == b) ? 32'd1 : 32'd0;
        KIND_GT:  res = (sa > sb) ? 32'd1 : 32'd0;
        KIND_LT:  res = (sa < sb) ? 32'd1 : 32'd0;
        KIND_AND: res = (a != '0 && b != '0) ? 32'd1 : 32'd0;
        default:  res = (a != '0 || b != '0) ? 32'd1 : 32'd0;
      endcase
      if (r.status == ST_OK) begin
        stack_fill--;
        stack_mirror[stack_fill - 1] = res;
      end
    end
    r.top_valid = (stack_fill > 0);
    r.top_value = (stack_fill > 0) ? stack_mirror[stack_fill - 1] : '0;
    r.depth     = DEPTH_W'(stack_fill);
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(15) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'd1;
      2: return ALL_ONES;
      3: return MOST_NEG;
      4: return MOST_POS;
      5: return 32'($urandom_range(20)) - 32'd10;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
  endtask

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value);
    in_kind  <= kind;
    in_value <= value;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_opcode(kind, value));
    items_sent++;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result beat check and receiver stall
  always @(posedge clk) begin
    step_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", '0, DATA_W'(out_status));
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", DATA_W'(want.status), DATA_W'(out_status));
          if (out_top_valid !== want.top_valid)
            report_mismatch("top_valid", DATA_W'(want.top_valid), DATA_W'(out_top_valid));
          if (out_top_value !== want.top_value)
            report_mismatch("top_value", want.top_value, out_top_value);
          if (out_depth !== want.depth)
            report_mismatch("depth", DATA_W'(want.depth), DATA_W'(out_depth));
          if (out_store_valid !== want.store_valid)
            report_mismatch("store_valid", DATA_W'(want.store_valid),
                            DATA_W'(out_store_valid));
          if (out_store_value !== want.store_value)
            report_mismatch("store_value", want.store_value, out_store_value);
        end
      end
      if (rx_hold) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if ($urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        stall_left = pick_gap() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL predicated_integer_stack_machine_top");
      $finish;
    end
  end

  task automatic test_directed();
    gap_pct = 20;
    stall_pct = 20;
    send_op(KIND_POP, $urandom());
    send_op(KIND_NOT, $urandom());
    send_op(KIND_IF, $urandom());
    send_op(KIND_EQ, $urandom());
    send_op(KIND_PUSH, '0);
    send_op(KIND_PUSH, 32'd7);
    send_op(KIND_DIV, $urandom());
    send_op(KIND_MOD, $urandom());
    send_op(KIND_SUB, $urandom());
    send_op(KIND_PUSH, ALL_ONES);
    send_op(KIND_PUSH, MOST_NEG);
    send_op(KIND_DIV, $urandom());
    send_op(KIND_GT, $urandom());
    send_op(KIND_PUSH, ALL_ONES);
    send_op(KIND_PUSH, MOST_NEG);
    send_op(KIND_MOD, $urandom());
    send_op(KIND_LT, $urandom());
    send_op(KIND_NOT, $urandom());
    send_op(KIND_PUSH, MOST_POS);
    send_op(KIND_ADD, $urandom());
    send_op(KIND_PUSH, 32'd3);
    send_op(KIND_MUL, $urandom());
    send_op(KIND_PUSH, 32'd1);
    send_op(KIND_AND, $urandom());
    send_op(KIND_PUSH, '0);
    send_op(KIND_OR, $urandom());
    send_op(KIND_IF, $urandom());
    send_op(KIND_PUSH, '0);
    send_op(KIND_IF, $urandom());
    send_op(KIND_PUSH, 32'd9);
    send_op(KIND_ELSE, $urandom());
    send_op(KIND_PUSH, ALL_ONES);
    send_op(KIND_POP, $urandom());
    send_op(KIND_ELSE, $urandom());
    send_op(KIND_SEP, $urandom());
    wait_idle();
  endtask

  task automatic test_output_hold();
    gap_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_op(KIND_SEP, $urandom());
    repeat (8) begin
      send_op(KIND_PUSH, pick_value());
      send_op(KIND_PUSH, pick_value());
      send_op(KIND_ADD + KIND_W'($urandom_range(KIND_OR - KIND_ADD)), $urandom());
      send_op(KIND_POP, $urandom());
    end
    wait_idle();
  endtask

  task automatic test_random_scripts(input int n_items);
    int stop_at;
    int next_switch;
    int n_ops;
    stop_at = items_sent + n_items;
    next_switch = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_switch) begin
        wait_idle();
        case ($urandom_range(3))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 20; stall_pct = 20; end
          2: begin gap_pct = 60; stall_pct = 60; end
          default: begin gap_pct = 50; stall_pct = 5; end
        endcase
        next_switch = items_sent + 80;
      end
      case ($urandom_range(15))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          if (stack_fill > 10) send_op(KIND_SEP, $urandom());
          while (stack_fill > 10) send_op(KIND_POP, $urandom());
          if ($urandom_range(7) == 0) send_op(KIND_SEP, $urandom());
          n_ops = $urandom_range(1, 3);
          repeat (n_ops + 1) send_op(KIND_PUSH, pick_value());
          repeat (n_ops)
            send_op(KIND_ADD + KIND_W'($urandom_range(KIND_OR - KIND_ADD)), $urandom());
          case ($urandom_range(3))
            0: send_op(KIND_NOT, $urandom());
            1: send_op(KIND_IF, $urandom());
            default: send_op(KIND_POP, $urandom());
          endcase
        end
        8, 9, 10, 11: begin
          send_op(KIND_SEP, $urandom());
          send_op(KIND_PUSH, $urandom_range(1) ? pick_value() : '0);
          send_op(KIND_IF, $urandom());
          send_op(KIND_PUSH, pick_value());
          send_op(KIND_PUSH, pick_value());
          send_op(KIND_ADD + KIND_W'($urandom_range(KIND_OR - KIND_ADD)), $urandom());
          send_op(KIND_ELSE, $urandom());
          send_op(KIND_PUSH, pick_value());
          send_op(KIND_NOT, $urandom());
          send_op(KIND_SEP, $urandom());
          send_op(KIND_POP, $urandom());
        end
        12: begin
          send_op(KIND_SEP, $urandom());
          while (stack_fill < STACK_DEPTH) send_op(KIND_PUSH, pick_value());
          repeat ($urandom_range(1, 3)) send_op(KIND_PUSH, pick_value());
          while (stack_fill > 0) send_op(KIND_POP, $urandom());
          send_op(KIND_NOT + KIND_W'($urandom_range(KIND_POP - KIND_NOT)), $urandom());
        end
        default: begin
          repeat ($urandom_range(1, 4)) send_op(KIND_W'($urandom_range(15)), $urandom());
        end
      endcase
    end
    wait_idle();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_kind    <= KIND_SEP;
    in_value   <= '0;
    rx_hold    <= 1'b0;
    gap_pct        = 0;
    stall_pct      = 0;
    items_sent     = 0;
    stack_fill     = 0;
    run_mirror     = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_output_hold();
    test_random_scripts(600);
    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS predicated_integer_stack_machine_top");
    end else begin
      $display("FAIL predicated_integer_stack_machine_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/pism_pkg.sv
rtl/core/predicated_integer_stack_machine_top.sv
tb/predicated_integer_stack_machine_top_tb.sv
